// File: sv/positional_insert_delete_array_assert.svh
// assertion macros for the positional insert/delete array
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PIDA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PIDA_ASSERT_NOW(lbl, ante, cons, msg)
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/pida_pkg.sv
package pida_pkg;

	localparam int CAPACITY_DEF  = 32;
	localparam int WORD_BITS_DEF = 32;

	localparam int OPCODE_W     = 3;
	localparam int POSITION_W   = 6;
	localparam int ITEM_W       = 32;
	localparam int FILL_W       = 6;
	localparam int SLOT_W       = 5;

	localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_INS_AT    = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DEL_BACK  = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_DEL_AT    = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_DUMP      = 3'd6;

	// what every cell does at a clock edge
	typedef enum logic [1:0] {
		CM_HOLD = 2'd0,
		CM_INS  = 2'd1,
		CM_DEL  = 2'd2,
		CM_ROT  = 2'd3
	} cell_mode_t;

endpackage

// File: sv/pida_cell.sv
module pida_cell
	import pida_pkg::*;
#(
	parameter int INDEX     = 0,
	parameter int IDX_W     = 5,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  cell_mode_t           mode,
	input  logic [IDX_W-1:0]     idx,
	input  logic [IDX_W-1:0]     top,
	input  logic [WORD_BITS-1:0] new_word,
	input  logic [WORD_BITS-1:0] left_word,
	input  logic [WORD_BITS-1:0] right_word,
	input  logic [WORD_BITS-1:0] head_word,
	output logic [WORD_BITS-1:0] word
);

	localparam logic [IDX_W-1:0] POS = IDX_W'(INDEX);

	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] word_d;

	always_comb begin
		word_d = word_q;
		case (mode)
			CM_INS: begin
				if (POS > idx) begin
					word_d = left_word;
				end else if (POS == idx) begin
					word_d = new_word;
				end
			end
			CM_DEL: begin
				if (POS >= idx) begin
					word_d = right_word;
				end
			end
			CM_ROT: begin
				// rotate the occupied part down, head wraps to the top slot
				if (POS == top) begin
					word_d = head_word;
				end else if (POS < top) begin
					word_d = right_word;
				end
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

// File: sv/pida_chain.sv
module pida_chain
	import pida_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int IDX_W     = $clog2(CAPACITY)
) (
	input  logic                 clk,
	input  cell_mode_t           mode,
	input  logic [IDX_W-1:0]     idx,
	input  logic [IDX_W-1:0]     top,
	input  logic [WORD_BITS-1:0] new_word,
	output logic [WORD_BITS-1:0] head_word
);

	logic [WORD_BITS-1:0] words [CAPACITY];

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = new_word;
		end else begin : g_mid_l
			assign left_w = words[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_w = words[g];
		end else begin : g_mid_r
			assign right_w = words[g+1];
		end

		pida_cell #(
			.INDEX     (g),
			.IDX_W     (IDX_W),
			.WORD_BITS (WORD_BITS)
		) u_cell (
			.clk        (clk),
			.mode       (mode),
			.idx        (idx),
			.top        (top),
			.new_word   (new_word),
			.left_word  (left_w),
			.right_word (right_w),
			.head_word  (words[0]),
			.word       (words[g])
		);
	end

	assign head_word = words[0];

endmodule

// File: sv/positional_insert_delete_array.sv
// insert/remove: one result, registered, the cycle after the item is accepted
// insert/remove throughput: one item per cycle while rsp_free; cells from the position up shift
// dump of n elements: results are loaded from the dump state, one per cycle while rsp_free;
// the chain rotates once per result, no new item is taken until the last dump result is loaded
// reset clears the element count and control; stored words are not reset
`include "positional_insert_delete_array_assert.svh"

module positional_insert_delete_array
	import pida_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  logic [OPCODE_W-1:0]   opcode,
	input  logic [POSITION_W-1:0] position,
	input  logic signed [ITEM_W-1:0] item_value,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic                  ok,
	output logic [FILL_W-1:0]     fill_count,
	output logic [SLOT_W-1:0]     slot,
	output logic signed [ITEM_W-1:0] slot_value,
	output logic                  last
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     dump_ptr_q;
	logic                 rsp_valid_q;
	logic                 ok_q;
	logic [FILL_W-1:0]    fill_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [ITEM_W-1:0]    value_q;
	logic                 last_q;

	logic                 rsp_free;
	logic                 accept;
	logic                 rsp_load;
	logic                 dump_step;
	logic                 dump_last;
	logic [CMP_W-1:0]     pos_w;
	logic [CMP_W-1:0]     cnt_w;
	logic [CMP_W-1:0]     ins_pos;
	logic [CMP_W-1:0]     del_pos;
	logic                 ins_ok;
	logic                 del_ok;
	logic                 is_ins;
	logic                 is_del;
	logic                 op_ok;
	logic [CNT_W-1:0]     count_d;
	cell_mode_t           mode;
	logic [IDX_W-1:0]     idx;
	logic [IDX_W-1:0]     top;
	logic [WORD_BITS-1:0] new_word;
	logic [WORD_BITS-1:0] head_word;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == ST_IDLE) && rsp_free;
	assign accept    = cmd_valid && cmd_ready;
	assign top       = IDX_W'(count_q - CNT_W'(1));
	assign dump_step = (state_q == ST_DUMP) && rsp_free;
	assign dump_last = (dump_ptr_q == top);
	assign rsp_load  = (accept && (opcode != OP_DUMP)) || dump_step;

	assign pos_w    = CMP_W'(position);
	assign cnt_w    = CMP_W'(count_q);
	assign new_word = WORD_BITS'($unsigned(item_value));

	always_comb begin
		ins_pos = pos_w;
		del_pos = pos_w;
		is_ins  = 1'b0;
		is_del  = 1'b0;
		unique case (opcode) inside
			OP_INS_FRONT: begin
				ins_pos = '0;
				is_ins  = 1'b1;
			end
			OP_INS_BACK: begin
				ins_pos = cnt_w;
				is_ins  = 1'b1;
			end
			OP_INS_AT: begin
				is_ins = 1'b1;
			end
			OP_DEL_FRONT: begin
				del_pos = '0;
				is_del  = 1'b1;
			end
			OP_DEL_BACK: begin
				del_pos = cnt_w - CMP_W'(1);
				is_del  = 1'b1;
			end
			OP_DEL_AT: begin
				is_del = 1'b1;
			end
			default: begin
				is_ins = 1'b0;
			end
		endcase
	end

	assign ins_ok = is_ins && (count_q < CNT_W'(CAPACITY)) && (ins_pos <= cnt_w);
	assign del_ok = is_del && (count_q != '0) && (del_pos < cnt_w);
	assign op_ok  = ins_ok || del_ok;

	always_comb begin
		mode    = CM_HOLD;
		idx     = '0;
		count_d = count_q;
		if (accept && ins_ok) begin
			mode    = CM_INS;
			idx     = IDX_W'(ins_pos);
			count_d = count_q + CNT_W'(1);
		end else if (accept && del_ok) begin
			mode    = CM_DEL;
			idx     = IDX_W'(del_pos);
			count_d = count_q - CNT_W'(1);
		end else if (dump_step) begin
			mode = CM_ROT;
		end
	end

	pida_chain #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS),
		.IDX_W     (IDX_W)
	) u_chain (
		.clk       (clk),
		.mode      (mode),
		.idx       (idx),
		.top       (top),
		.new_word  (new_word),
		.head_word (head_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dump_ptr_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == OP_DUMP) && (count_q != '0)) begin
						state_q    <= ST_DUMP;
						dump_ptr_q <= '0;
					end
				end
				ST_DUMP: begin
					if (rsp_free) begin
						dump_ptr_q <= dump_ptr_q + IDX_W'(1);
						if (dump_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (opcode != OP_DUMP)) begin
			ok_q    <= op_ok;
			fill_q  <= FILL_W'(count_d);
			slot_q  <= '0;
			value_q <= '0;
			last_q  <= 1'b1;
		end else if (dump_step) begin
			ok_q    <= 1'b1;
			fill_q  <= FILL_W'(count_q);
			slot_q  <= SLOT_W'(dump_ptr_q);
			value_q <= ITEM_W'($signed(head_word));
			last_q  <= dump_last;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign ok         = ok_q;
	assign fill_count = fill_q;
	assign slot       = slot_q;
	assign slot_value = value_q;
	assign last       = last_q;

	`PIDA_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`PIDA_ASSERT_NOW(a_no_cmd_in_dump, state_q == ST_DUMP, !cmd_ready, "item taken during dump")
	`PIDA_ASSERT_NEXT(a_dump_ends, dump_step && dump_last, state_q == ST_IDLE, "dump did not end")
	`PIDA_ASSERT_NEXT(a_dump_count, state_q == ST_DUMP, $stable(count_q), "count moved in dump")
	`PIDA_ASSERT_NEXT(a_empty_dump, accept && (opcode == OP_DUMP) && (count_q == '0), !rsp_valid_q, "empty dump gave a result")

endmodule

// File: dv/positional_insert_delete_array_checker.sv
`timescale 1ns / 1ps

module positional_insert_delete_array_checker
	import pida_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  logic                     cmd_ready,
	input  logic [OPCODE_W-1:0]      opcode,
	input  logic [POSITION_W-1:0]    position,
	input  logic signed [ITEM_W-1:0] item_value,
	input  logic                     rsp_valid,
	input  logic                     rsp_ready,
	input  logic                     ok,
	input  logic [FILL_W-1:0]        fill_count,
	input  logic [SLOT_W-1:0]        slot,
	input  logic signed [ITEM_W-1:0] slot_value,
	input  logic                     last,
	output int                       mismatches,
	output int                       awaited,
	output int                       list_len
);

	typedef struct packed {
		logic                     ok;
		logic [FILL_W-1:0]        fill;
		logic [SLOT_W-1:0]        slot;
		logic signed [ITEM_W-1:0] word;
		logic                     last;
	} list_result_t;

	list_result_t             pending_results[$];
	logic signed [ITEM_W-1:0] stored_words[$];
	int                       fail_total;

	function automatic bit try_insert(int idx, logic signed [ITEM_W-1:0] w);
		if (stored_words.size() >= CAPACITY_DEF || idx > stored_words.size())
			return 1'b0;
		stored_words.insert(idx, w);
		return 1'b1;
	endfunction

	function automatic bit try_remove(int idx);
		if (stored_words.size() == 0 || idx >= stored_words.size())
			return 1'b0;
		stored_words.delete(idx);
		return 1'b1;
	endfunction

	function automatic void predict_list_op(logic [OPCODE_W-1:0] op,
			logic [POSITION_W-1:0] pos, logic signed [ITEM_W-1:0] w);
		list_result_t r;
		bit           done;
		int           n;
		n = stored_words.size();
		done = 1'b0;
		case (op)
			OP_INS_FRONT: done = try_insert(0, w);
			OP_INS_BACK:  done = try_insert(n, w);
			OP_INS_AT:    done = try_insert(int'(pos), w);
			OP_DEL_FRONT: done = try_remove(0);
			OP_DEL_BACK: begin
				if (n > 0)
					done = try_remove(n - 1);
			end
			OP_DEL_AT:    done = try_remove(int'(pos));
			OP_DUMP: begin
				for (int i = 0; i < n; i++) begin
					r.ok   = 1'b1;
					r.fill = FILL_W'(n);
					r.slot = SLOT_W'(i);
					r.word = stored_words[i];
					r.last = (i == n - 1);
					pending_results.push_back(r);
				end
				return;
			end
			default: done = 1'b0;
		endcase
		r.ok   = done;
		r.fill = FILL_W'(stored_words.size());
		r.slot = '0;
		r.word = '0;
		r.last = 1'b1;
		pending_results.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t seen;
		list_result_t want;
		if (!arst_n) begin
			pending_results.delete();
			stored_words.delete();
			fail_total = 0;
			mismatches <= 0;
			awaited <= 0;
			list_len <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				seen = {ok, fill_count, slot, slot_value, last};
				if (pending_results.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: unexpected item ok=%0d fill=%0d slot=%0d value=%0d last=%0d",
							$time, seen.ok, seen.fill, seen.slot, seen.word, seen.last);
				end else begin
					want = pending_results.pop_front();
					if (seen !== want) begin
						fail_total++;
						if (fail_total <= 10) begin
							$display("%0t: expected ok=%0d fill=%0d slot=%0d value=%0d last=%0d",
								$time, want.ok, want.fill, want.slot, want.word, want.last);
							$display("%0t:   actual ok=%0d fill=%0d slot=%0d value=%0d last=%0d",
								$time, seen.ok, seen.fill, seen.slot, seen.word, seen.last);
						end
					end
				end
			end
			if (cmd_valid && cmd_ready)
				predict_list_op(opcode, position, item_value);
			mismatches <= fail_total;
			awaited <= pending_results.size();
			list_len <= stored_words.size();
		end
	end

endmodule

// File: dv/positional_insert_delete_array_test.sv
`timescale 1ns / 1ps

module positional_insert_delete_array_test
	import pida_pkg::*;
();

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
	localparam logic signed [ITEM_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [ITEM_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cmd_valid = 1'b0;
	logic                     cmd_ready;
	logic [OPCODE_W-1:0]      opcode = '0;
	logic [POSITION_W-1:0]    position = '0;
	logic signed [ITEM_W-1:0] item_value = '0;
	logic                     rsp_valid;
	logic                     rsp_ready = 1'b0;
	logic                     ok;
	logic [FILL_W-1:0]        fill_count;
	logic [SLOT_W-1:0]        slot;
	logic signed [ITEM_W-1:0] slot_value;
	logic                     last;

	int mismatches;
	int awaited;
	int list_len;
	int accepted_items = 0;
	int rx_gap = 0;
	bit rx_hold = 1'b0;
	bit no_idle = 1'b0;

	int ins_mix[5] = '{85, 45, 10, 85, 45};
	int del_mix[5] = '{10, 45, 85, 10, 45};

	positional_insert_delete_array dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.opcode     (opcode),
		.position   (position),
		.item_value (item_value),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.ok         (ok),
		.fill_count (fill_count),
		.slot       (slot),
		.slot_value (slot_value),
		.last       (last)
	);

	positional_insert_delete_array_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.opcode     (opcode),
		.position   (position),
		.item_value (item_value),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.ok         (ok),
		.fill_count (fill_count),
		.slot       (slot),
		.slot_value (slot_value),
		.last       (last),
		.mismatches (mismatches),
		.awaited    (awaited),
		.list_len   (list_len)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stall per item, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		int draw;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rx_gap <= 0;
		end else if (rx_hold) begin
			rsp_ready <= 1'b0;
		end else if (rsp_ready) begin
			if (rsp_valid && !no_idle) begin
				draw = $urandom_range(0, 5);
				if (draw != 0) begin
					rsp_ready <= 1'b0;
					rx_gap <= draw - 1;
				end
			end
		end else if (rx_gap != 0) begin
			rx_gap <= rx_gap - 1;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		wait (accepted_items >= 80);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (200) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [POSITION_W-1:0] pos,
			input logic signed [ITEM_W-1:0] w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= op;
		position <= pos;
		item_value <= w;
		do @(posedge clk); while (!cmd_ready);
		accepted_items++;
	endtask

	task automatic send_random_item(input int ins_pct, input int del_pct);
		logic [OPCODE_W-1:0]      op;
		logic [POSITION_W-1:0]    pos;
		logic signed [ITEM_W-1:0] w;
		int                       pick;
		int                       kind;
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 2);
		if (pick < ins_pct)
			op = (kind == 0) ? OP_INS_FRONT : (kind == 1) ? OP_INS_BACK : OP_INS_AT;
		else if (pick < ins_pct + del_pct)
			op = (kind == 0) ? OP_DEL_FRONT : (kind == 1) ? OP_DEL_BACK : OP_DEL_AT;
		else if (pick < 98)
			op = OP_DUMP;
		else
			op = OP_UNUSED;
		if ($urandom_range(0, 3) == 0)
			pos = POSITION_W'($urandom_range(0, 63));
		else
			pos = POSITION_W'($urandom_range(0, list_len + 1));
		case ($urandom_range(0, 11))
			0:       w = WORD_MIN;
			1:       w = WORD_MAX;
			2:       w = '0;
			3:       w = -1;
			default: w = $urandom();
		endcase
		send_item(op, pos, w);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		send_item(OP_DEL_FRONT, 6'd0, 32'sd5);
		send_item(OP_DEL_BACK, 6'd0, 32'sd5);
		send_item(OP_DEL_AT, 6'd0, 32'sd5);
		send_item(OP_DUMP, 6'd0, 32'sd0);
		send_item(OP_INS_AT, 6'd1, 32'sd9);
		// fill a few, extremes of the word
		send_item(OP_INS_FRONT, 6'd0, WORD_MIN);
		send_item(OP_INS_BACK, 6'd63, WORD_MAX);
		send_item(OP_INS_AT, 6'd1, -32'sd1);
		send_item(OP_INS_AT, 6'd3, 32'sd0);
		send_item(OP_INS_AT, 6'd63, 32'sd7);
		send_item(OP_DUMP, 6'd63, -32'sd1);
		// bad remove index, then removes down to empty, an unused opcode and dumps
		send_item(OP_DEL_AT, 6'd4, 32'sd0);
		send_item(OP_DEL_AT, 6'd63, 32'sd0);
		send_item(OP_DEL_AT, 6'd1, 32'sd0);
		send_item(OP_UNUSED, 6'd63, -32'sd1);
		send_item(OP_DEL_FRONT, 6'd0, 32'sd0);
		send_item(OP_DEL_BACK, 6'd0, 32'sd0);
		send_item(OP_DUMP, 6'd0, 32'sd0);
		send_item(OP_DEL_BACK, 6'd0, 32'sd0);
		send_item(OP_DUMP, 6'd0, 32'sd0);

		// fill, churn, drain, fast fill, churn
		for (int ph = 0; ph < 5; ph++) begin
			no_idle <= (ph == 3);
			for (int i = 0; i < 50; i++)
				send_random_item(ins_mix[ph], del_mix[ph]);
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
